// File: hdl/stok_pkg.sv
package stok_pkg;

   // name buffer geometry
   localparam int MAX_NAME = 32;
   localparam int NAME_AW  = $clog2(MAX_NAME);
   localparam int LEN_W    = $clog2(MAX_NAME + 1);

   // command queue geometry
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = Q_AW + 1;

   // token kinds
   localparam logic [4:0] KIND_NEWLINE = 5'd0;
   localparam logic [4:0] KIND_PLUS    = 5'd1;
   localparam logic [4:0] KIND_MINUS   = 5'd2;
   localparam logic [4:0] KIND_ARROW   = 5'd3;
   localparam logic [4:0] KIND_STAR    = 5'd4;
   localparam logic [4:0] KIND_SLASH   = 5'd5;
   localparam logic [4:0] KIND_GT      = 5'd6;
   localparam logic [4:0] KIND_GTE     = 5'd7;
   localparam logic [4:0] KIND_LT      = 5'd8;
   localparam logic [4:0] KIND_LTE     = 5'd9;
   localparam logic [4:0] KIND_LPAREN  = 5'd10;
   localparam logic [4:0] KIND_RPAREN  = 5'd11;
   localparam logic [4:0] KIND_LBRACE  = 5'd12;
   localparam logic [4:0] KIND_RBRACE  = 5'd13;
   localparam logic [4:0] KIND_SEMI    = 5'd14;
   localparam logic [4:0] KIND_IDENT   = 5'd15;
   localparam logic [4:0] KIND_KW0     = 5'd16;
   localparam logic [4:0] KIND_ERROR   = 5'd23;
   localparam logic [4:0] KIND_END     = 5'd24;

   // control characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // keyword table
   localparam int KW_COUNT = 7;
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"#", "d", "e", "f", "i", "n", "e", CH_NUL},
      '{"#", "i", "f", "d", "e", "f", CH_NUL, CH_NUL},
      '{"#", "i", "f", "n", "d", "e", "f", CH_NUL},
      '{"#", "e", "n", "d", "i", "f", CH_NUL, CH_NUL},
      '{"v", "o", "i", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"p", "r", "o", "c", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
      '{"p", "u", "b", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd7, 3'd6, 3'd7, 3'd6, 3'd4, 3'd4, 3'd3};

   // pending token in the front
   typedef enum logic [2:0] {
      M_IDLE,
      M_MINUS,
      M_GT,
      M_LT,
      M_IDENT
   } mode_type;

   // back sequencer
   typedef enum logic {
      B_IDLE,
      B_RUN
   } back_state_type;

   // command opcodes
   typedef enum logic [1:0] {
      OP_TOKEN,
      OP_APPEND,
      OP_IDENT
   } cmd_op_type;

   // one queued command: a single token, a buffer write, or an identifier run
   typedef struct packed {
      cmd_op_type       op;
      logic [4:0]       kind;
      logic [7:0]       ch;
      logic [LEN_W-1:0] len;
      logic             trunc;
      logic [31:0]      line;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_FF);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_letter(c) || ((c >= "0") && (c <= "9")) || (c == "_");
   endfunction

endpackage

// File: hdl/stok_queue.sv
module stok_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stok_pkg::cmd_type     push_cmd,
   input  logic                  pop,
   output stok_pkg::cmd_type     head,
   output stok_pkg::q_status_type q_st
);
   import stok_pkg::*;

   cmd_type         entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_AW'(1);
      end
      count_in = count_ff + Q_CW'(push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign q_st.full  = (count_ff == Q_CW'(Q_DEPTH));
   assign q_st.empty = (count_ff == '0);

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push |-> !q_st.full) and (pop |-> !q_st.empty))
      else $error("command queue overrun or underrun");

endmodule

// File: hdl/stok_front.sv
module stok_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_input,
   output logic                   push,
   output stok_pkg::cmd_type      push_cmd,
   input  stok_pkg::q_status_type q_st
);
   import stok_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [LEN_W-1:0]  name_len_ff, name_len_in;
   logic              ovf_ff, ovf_in;
   logic [KW_COUNT-1:0] match_ff, match_in, match_init, match_step;
   logic [31:0]       line_ff, line_in, line_next;
   cmd_type           spill_ff;
   logic              spill_valid_ff, spill_valid_in;

   logic       accept;
   logic [7:0] c;
   logic       is_end;
   logic [4:0] ident_kind;

   logic     start_valid;
   mode_type start_mode;
   cmd_type  start_cmd;
   cmd_type  flush_cmd;
   cmd_type  special_cmd;
   logic     special_valid, take_flush, take_start;
   logic     first_valid, second_valid;
   cmd_type  second_cmd;
   cmd_type  cmd_a, cmd_b;
   logic     a_valid, b_valid;

   function automatic cmd_type mk_cmd(input cmd_op_type op, input logic [4:0] kind,
                                      input logic [7:0] ch, input logic [LEN_W-1:0] len,
                                      input logic trunc, input logic [31:0] line);
      cmd_type r;
      r.op    = op;
      r.kind  = kind;
      r.ch    = ch;
      r.len   = len;
      r.trunc = trunc;
      r.line  = line;
      return r;
   endfunction

   assign req_stall = spill_valid_ff || q_st.full;
   assign accept    = req_valid && !req_stall;
   assign c         = req_text_byte;
   assign is_end    = req_end_of_input || (c == CH_NUL);
   assign line_next = ((c == CH_NL) && !is_end && (line_ff != '1)) ? line_ff + 32'd1 : line_ff;

   // incremental keyword match
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         match_init[k] = (KW_TEXT[k][0] == c);
         match_step[k] = match_ff[k] && (name_len_ff < LEN_W'(KW_LEN[k]))
                         && (KW_TEXT[k][name_len_ff[2:0]] == c);
      end
   end

   always_comb begin
      ident_kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!ovf_ff && match_ff[k] && (name_len_ff == LEN_W'(KW_LEN[k]))) begin
            ident_kind = KIND_KW0 + 5'(k);
         end
      end
   end

   // what a byte does when no token is pending
   always_comb begin
      start_valid = 1'b1;
      start_mode  = M_IDLE;
      start_cmd   = mk_cmd(OP_TOKEN, KIND_ERROR, c, '0, 1'b0, line_next);
      unique case (c)
         CH_SPACE, CH_TAB, CH_CR, CH_FF: start_valid = 1'b0;
         CH_NL: start_cmd.kind = KIND_NEWLINE;
         "+":   start_cmd.kind = KIND_PLUS;
         "*":   start_cmd.kind = KIND_STAR;
         "/":   start_cmd.kind = KIND_SLASH;
         "(":   start_cmd.kind = KIND_LPAREN;
         ")":   start_cmd.kind = KIND_RPAREN;
         "{":   start_cmd.kind = KIND_LBRACE;
         "}":   start_cmd.kind = KIND_RBRACE;
         ";":   start_cmd.kind = KIND_SEMI;
         "-": begin
            start_valid = 1'b0;
            start_mode  = M_MINUS;
         end
         ">": begin
            start_valid = 1'b0;
            start_mode  = M_GT;
         end
         "<": begin
            start_valid = 1'b0;
            start_mode  = M_LT;
         end
         default: begin
            if (is_letter(c) || (c == "_") || (c == "#")) begin
               start_mode = M_IDENT;
               start_cmd  = mk_cmd(OP_APPEND, KIND_IDENT, c, '0, 1'b0, line_next);
            end
         end
      endcase
   end

   // commands for the accepted byte, at most two
   always_comb begin
      unique case (mode_ff)
         M_MINUS: flush_cmd = mk_cmd(OP_TOKEN, KIND_MINUS, "-", '0, 1'b0, line_next);
         M_GT:    flush_cmd = mk_cmd(OP_TOKEN, KIND_GT, ">", '0, 1'b0, line_next);
         M_LT:    flush_cmd = mk_cmd(OP_TOKEN, KIND_LT, "<", '0, 1'b0, line_next);
         M_IDENT: flush_cmd = mk_cmd(OP_IDENT, ident_kind, CH_NUL, name_len_ff, ovf_ff,
                                     line_next);
         default: flush_cmd = mk_cmd(OP_TOKEN, KIND_END, CH_NUL, '0, 1'b0, line_next);
      endcase

      special_valid = 1'b0;
      special_cmd   = start_cmd;
      take_flush    = 1'b0;
      take_start    = 1'b0;
      if (is_end) begin
         take_flush    = 1'b1;
         special_valid = 1'b1;
         special_cmd   = mk_cmd(OP_TOKEN, KIND_END, CH_NUL, '0, 1'b0, line_next);
      end else begin
         unique case (mode_ff)
            M_MINUS: begin
               if (c == ">") begin
                  special_valid = 1'b1;
                  special_cmd   = mk_cmd(OP_TOKEN, KIND_ARROW, "-", '0, 1'b0, line_next);
               end else if (!is_blank(c)) begin
                  take_flush = 1'b1;
                  take_start = 1'b1;
               end
            end
            M_GT, M_LT: begin
               if (c == "=") begin
                  special_valid = 1'b1;
                  special_cmd   = (mode_ff == M_GT)
                                  ? mk_cmd(OP_TOKEN, KIND_GTE, ">", '0, 1'b0, line_next)
                                  : mk_cmd(OP_TOKEN, KIND_LTE, "<", '0, 1'b0, line_next);
               end else begin
                  take_flush = 1'b1;
                  take_start = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_name_char(c)) begin
                  if (name_len_ff < LEN_W'(MAX_NAME)) begin
                     special_valid = 1'b1;
                     special_cmd   = mk_cmd(OP_APPEND, KIND_IDENT, c, name_len_ff, 1'b0,
                                            line_next);
                  end
               end else begin
                  take_flush = 1'b1;
                  take_start = 1'b1;
               end
            end
            default: take_start = 1'b1;
         endcase
      end

      first_valid  = take_flush && (mode_ff != M_IDLE);
      second_valid = special_valid || (take_start && start_valid);
      second_cmd   = special_valid ? special_cmd : start_cmd;
      a_valid      = first_valid || second_valid;
      cmd_a        = first_valid ? flush_cmd : second_cmd;
      b_valid      = first_valid && second_valid;
      cmd_b        = second_cmd;

      // the spilled second command goes first, nothing is accepted meanwhile
      push           = spill_valid_ff ? !q_st.full : (accept && a_valid);
      push_cmd       = spill_valid_ff ? spill_ff : cmd_a;
      spill_valid_in = spill_valid_ff ? q_st.full : (accept && b_valid);
   end

   // pending token state
   always_comb begin
      logic do_start;
      do_start    = 1'b0;
      mode_in     = mode_ff;
      name_len_in = name_len_ff;
      ovf_in      = ovf_ff;
      match_in    = match_ff;
      line_in     = line_ff;
      if (accept) begin
         line_in = line_next;
         if (is_end) begin
            mode_in     = M_IDLE;
            name_len_in = '0;
            ovf_in      = 1'b0;
         end else begin
            unique case (mode_ff)
               M_MINUS: begin
                  if (c == ">") begin
                     mode_in = M_IDLE;
                  end else if (!is_blank(c)) begin
                     do_start = 1'b1;
                  end
               end
               M_GT, M_LT: begin
                  if (c == "=") begin
                     mode_in = M_IDLE;
                  end else begin
                     do_start = 1'b1;
                  end
               end
               M_IDENT: begin
                  if (is_name_char(c)) begin
                     if (name_len_ff < LEN_W'(MAX_NAME)) begin
                        name_len_in = name_len_ff + LEN_W'(1);
                        match_in    = match_step;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end else begin
                     do_start = 1'b1;
                  end
               end
               default: do_start = 1'b1;
            endcase
         end
         if (do_start) begin
            mode_in     = start_mode;
            name_len_in = (start_mode == M_IDENT) ? LEN_W'(1) : '0;
            ovf_in      = 1'b0;
            match_in    = match_init;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_IDLE;
         name_len_ff    <= '0;
         ovf_ff         <= 1'b0;
         match_ff       <= '0;
         line_ff        <= '0;
         spill_valid_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         name_len_ff    <= name_len_in;
         ovf_ff         <= ovf_in;
         match_ff       <= match_in;
         line_ff        <= line_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && b_valid) begin
         spill_ff <= cmd_b;
      end
   end

   a_ident_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_IDENT) |-> ((name_len_ff != '0) && (name_len_ff <= LEN_W'(MAX_NAME))))
      else $error("identifier length out of range");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> ((mode_ff == M_IDENT) && (name_len_ff == LEN_W'(MAX_NAME))))
      else $error("overflow without a full buffer");

endmodule

// File: hdl/stok_back.sv
module stok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  stok_pkg::cmd_type      head,
   input  stok_pkg::q_status_type q_st,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [4:0]             rsp_kind,
   output logic [7:0]             rsp_char_out,
   output logic [4:0]             rsp_char_index,
   output logic                   rsp_last,
   output logic                   rsp_truncated,
   output logic [31:0]            rsp_line
);
   import stok_pkg::*;

   back_state_type   state_ff, state_in;
   logic [7:0]       name_mem [MAX_NAME];
   logic [7:0]       rd_data_ff;
   logic [NAME_AW-1:0] rd_addr;
   logic             wr_en;

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [4:0]       run_kind_ff;
   logic [LEN_W-1:0] run_len_ff;
   logic             run_trunc_ff;
   logic [31:0]      run_line_ff;
   logic             run_start;
   logic             run_last;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_kind_ff;
   logic [7:0]       rsp_char_out_ff;
   logic [4:0]       rsp_char_index_ff;
   logic             rsp_last_ff;
   logic             rsp_truncated_ff;
   logic [31:0]      rsp_line_ff;

   logic             out_ready;
   logic             load;
   logic [4:0]       ld_kind;
   logic [7:0]       ld_ch;
   logic [4:0]       ld_idx;
   logic             ld_last;
   logic             ld_trunc;
   logic [31:0]      ld_line;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign run_last  = ((idx_ff + LEN_W'(1)) == run_len_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_st.empty && (head.op == OP_IDENT)) begin
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (out_ready && run_last) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      wr_en     = 1'b0;
      run_start = 1'b0;
      load      = 1'b0;
      rd_addr   = '0;
      idx_in    = idx_ff;
      ld_kind   = head.kind;
      ld_ch     = head.ch;
      ld_idx    = '0;
      ld_last   = 1'b1;
      ld_trunc  = 1'b0;
      ld_line   = head.line;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_st.empty) begin
               unique case (head.op)
                  OP_TOKEN: begin
                     pop  = out_ready;
                     load = out_ready;
                  end
                  OP_APPEND: begin
                     pop   = 1'b1;
                     wr_en = 1'b1;
                  end
                  OP_IDENT: begin
                     pop       = 1'b1;
                     run_start = 1'b1;
                     idx_in    = '0;
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         B_RUN: begin
            ld_kind  = run_kind_ff;
            ld_ch    = rd_data_ff;
            ld_idx   = 5'(idx_ff);
            ld_last  = run_last;
            ld_trunc = run_trunc_ff;
            ld_line  = run_line_ff;
            rd_addr  = idx_ff[NAME_AW-1:0];
            if (out_ready) begin
               load = 1'b1;
               if (!run_last) begin
                  idx_in  = idx_ff + LEN_W'(1);
                  rd_addr = idx_in[NAME_AW-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // name buffer, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[head.len[NAME_AW-1:0]] <= head.ch;
      end
      rd_data_ff <= name_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (run_start) begin
         run_kind_ff  <= head.kind;
         run_len_ff   <= head.len;
         run_trunc_ff <= head.trunc;
         run_line_ff  <= head.line;
      end
      if (load) begin
         rsp_kind_ff       <= ld_kind;
         rsp_char_out_ff   <= ld_ch;
         rsp_char_index_ff <= ld_idx;
         rsp_last_ff       <= ld_last;
         rsp_truncated_ff  <= ld_trunc;
         rsp_line_ff       <= ld_line;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_char_out   = rsp_char_out_ff;
   assign rsp_char_index = rsp_char_index_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_truncated  = rsp_truncated_ff;
   assign rsp_line       = rsp_line_ff;

   a_run_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (idx_ff < run_len_ff))
      else $error("identifier run index past its length");

   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff == B_RUN))
      else $error("non-final word outside an identifier run");

endmodule

// File: hdl/source_tokenizer_top.sv
// source tokenizer: takes one source byte per req word and returns token words on rsp. a front
// stage classifies each byte (blanks dropped, newlines counted into a saturating 32-bit line
// count, '-' blanks '>' folded into an arrow, '>=' and '<=' folded) and queues up to two
// commands per byte in a four-entry command queue; a back stage carries them out. most bytes
// are taken one per cycle while the queue has room; a byte that closes a pending token and
// gives a word or buffer write of its own (an end word included) holds off the next byte
// until its second command is queued. identifiers are written into a MAX_NAME byte buffer
// and come out one character per rsp word once the identifier ends, with the keyword kind
// already known and last set on the final character; names longer than MAX_NAME are cut
// and flagged truncated. the back starts an identifier's buffer read and then sends its
// characters while the front keeps taking bytes until the queue fills. end_of_input or a
// zero byte flushes whatever is pending and returns an end word. there is no reset sweep
module source_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_input,
   // token stream out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic [4:0]  rsp_char_index,
   output logic        rsp_last,
   output logic        rsp_truncated,
   output logic [31:0] rsp_line
);
   import stok_pkg::*;

   // front to queue
   logic         push;
   cmd_type      push_cmd;
   // queue to back
   logic         pop;
   cmd_type      head;
   q_status_type q_st;

   // classifier: holds the pending token, line count and keyword match bits
   stok_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .push             (push),
      .push_cmd         (push_cmd),
      .q_st             (q_st)
   );

   // decouples byte intake from token output
   stok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_st     (q_st)
   );

   // executor: owns the name buffer and the output register
   stok_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_st           (q_st),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_char_out   (rsp_char_out),
      .rsp_char_index (rsp_char_index),
      .rsp_last       (rsp_last),
      .rsp_truncated  (rsp_truncated),
      .rsp_line       (rsp_line)
   );

endmodule

// File: tb/tb_source_tokenizer_top.sv
module tb_source_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import stok_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_BYTES = 260;
   localparam int REPORT_MAX   = 10;

   // one source byte as it goes out on req
   typedef struct packed {
      logic [7:0] text;
      logic       eoi;
   } src_word_type;

   // one token word as it comes back on rsp
   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  ch;
      logic [4:0]  idx;
      logic        last;
      logic        trunc;
      logic [31:0] line;
   } token_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_kind;
   logic [7:0]  rsp_char_out;
   logic [4:0]  rsp_char_index;
   logic        rsp_last;
   logic        rsp_truncated;
   logic [31:0] rsp_line;

   source_tokenizer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_char_index   (rsp_char_index),
      .rsp_last         (rsp_last),
      .rsp_truncated    (rsp_truncated),
      .rsp_line         (rsp_line)
   );

   always #5 clock = ~clock;

   // source bytes waiting for the driver, token words waiting for the monitor
   src_word_type   source_q[$];
   token_word_type token_expect_q[$];

   int unsigned cycle_count = 0;
   int unsigned fail_count  = 0;

   // no random idling on either side inside this window
   wire quiet = (cycle_count >= 300) && (cycle_count < 700);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // lexer prediction: its own copy of the pending token, name buffer and
   // line count, advanced once per accepted source word
   // ---------------------------------------------------------------------
   mode_type    lex_mode = M_IDLE;
   logic [7:0]  name_buf [MAX_NAME];
   int unsigned name_len = 0;
   logic        name_cut = 1'b0;
   logic [31:0] line_total = 32'd0;

   string kw_word [KW_COUNT] = '{"#define", "#ifdef", "#ifndef", "#endif",
                                 "void", "proc", "pub"};

   function automatic logic byte_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_FF;
   endfunction

   function automatic logic byte_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic byte_in_name(input logic [7:0] c);
      return byte_alpha(c) || (c >= "0" && c <= "9") || c == "_";
   endfunction

   // every token word carries the line count as it stands when it is made
   function automatic void push_token(input logic [4:0] kind, input logic [7:0] ch,
                                      input logic [4:0] idx, input logic last,
                                      input logic trunc);
      token_word_type w;
      w.kind  = kind;
      w.ch    = ch;
      w.idx   = idx;
      w.last  = last;
      w.trunc = trunc;
      w.line  = line_total;
      token_expect_q.push_back(w);
   endfunction

   // keyword lookup; a cut name is always a plain identifier
   function automatic logic [4:0] name_kind();
      logic hit;
      if (name_cut)
         return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (kw_word[k].len() == name_len);
         for (int i = 0; i < kw_word[k].len() && hit; i++)
            if (name_buf[i] != kw_word[k][i])
               hit = 1'b0;
         if (hit)
            return KIND_KW0 + 5'(k);
      end
      return KIND_IDENT;
   endfunction

   function automatic void flush_pending_token();
      logic [4:0] kind;
      case (lex_mode)
         M_MINUS: push_token(KIND_MINUS, "-", 5'd0, 1'b1, 1'b0);
         M_GT:    push_token(KIND_GT, ">", 5'd0, 1'b1, 1'b0);
         M_LT:    push_token(KIND_LT, "<", 5'd0, 1'b1, 1'b0);
         M_IDENT: begin
            kind = name_kind();
            for (int i = 0; i < name_len; i++)
               push_token(kind, name_buf[i], 5'(i), (i + 1 == name_len), name_cut);
         end
         default: ;
      endcase
      lex_mode = M_IDLE;
      name_len = 0;
      name_cut = 1'b0;
   endfunction

   function automatic void begin_token(input logic [7:0] c);
      if (byte_blank(c))
         return;
      case (c)
         CH_NL: push_token(KIND_NEWLINE, c, 5'd0, 1'b1, 1'b0);
         "+":   push_token(KIND_PLUS, c, 5'd0, 1'b1, 1'b0);
         "*":   push_token(KIND_STAR, c, 5'd0, 1'b1, 1'b0);
         "/":   push_token(KIND_SLASH, c, 5'd0, 1'b1, 1'b0);
         "(":   push_token(KIND_LPAREN, c, 5'd0, 1'b1, 1'b0);
         ")":   push_token(KIND_RPAREN, c, 5'd0, 1'b1, 1'b0);
         "{":   push_token(KIND_LBRACE, c, 5'd0, 1'b1, 1'b0);
         "}":   push_token(KIND_RBRACE, c, 5'd0, 1'b1, 1'b0);
         ";":   push_token(KIND_SEMI, c, 5'd0, 1'b1, 1'b0);
         "-":   lex_mode = M_MINUS;
         ">":   lex_mode = M_GT;
         "<":   lex_mode = M_LT;
         default: begin
            if (byte_alpha(c) || c == "_" || c == "#") begin
               name_buf[0] = c;
               name_len    = 1;
               name_cut    = 1'b0;
               lex_mode    = M_IDENT;
            end else begin
               push_token(KIND_ERROR, c, 5'd0, 1'b1, 1'b0);
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(input logic [7:0] c, input logic eoi);
      // end word or a nul byte: flush whatever is pending, then end
      if (eoi || c == CH_NUL) begin
         flush_pending_token();
         push_token(KIND_END, CH_NUL, 5'd0, 1'b1, 1'b0);
         return;
      end
      // newline counts before any flush, so a flushed token sees the new line
      if (c == CH_NL && line_total != 32'hFFFF_FFFF)
         line_total++;
      case (lex_mode)
         M_MINUS: begin
            // blanks keep the arrow alive
            if (byte_blank(c))
               return;
            if (c == ">") begin
               push_token(KIND_ARROW, "-", 5'd0, 1'b1, 1'b0);
               lex_mode = M_IDLE;
               return;
            end
            flush_pending_token();
         end
         M_GT, M_LT: begin
            if (c == "=") begin
               if (lex_mode == M_GT)
                  push_token(KIND_GTE, ">", 5'd0, 1'b1, 1'b0);
               else
                  push_token(KIND_LTE, "<", 5'd0, 1'b1, 1'b0);
               lex_mode = M_IDLE;
               return;
            end
            flush_pending_token();
         end
         M_IDENT: begin
            if (byte_in_name(c)) begin
               // past the buffer the name is only marked as cut
               if (name_len < MAX_NAME) begin
                  name_buf[name_len] = c;
                  name_len++;
               end else begin
                  name_cut = 1'b1;
               end
               return;
            end
            flush_pending_token();
         end
         default: lex_mode = M_IDLE;
      endcase
      begin_token(c);
   endfunction

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b, input logic eoi);
      src_word_type w;
      w.text = b;
      w.eoi  = eoi;
      source_q.push_back(w);
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], 1'b0);
   endfunction

   // any character that may continue a name
   function automatic logic [7:0] rand_name_char();
      int unsigned n;
      n = $urandom_range(0, 62);
      if (n < 26)
         return 8'("a" + n);
      if (n < 52)
         return 8'("A" + n - 26);
      if (n < 62)
         return 8'("0" + n - 52);
      return "_";
   endfunction

   // a name start: letter, underscore or hash
   function automatic logic [7:0] rand_name_head();
      case ($urandom_range(0, 5))
         0:       return "_";
         1:       return "#";
         2:       return 8'("A" + $urandom_range(0, 25));
         default: return 8'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   // something that mostly ends a name or token: blank, newline, operator or noise
   function automatic logic [7:0] rand_break();
      string breaks;
      breaks = " \t\r\f\n+-*/<>(){};=@";
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(1, 255));
      return breaks[$urandom_range(0, breaks.len() - 1)];
   endfunction

   // random part: mostly well formed token sequences with random content,
   // the rest noise bytes, stray end words, nul bytes and newlines
   function automatic void add_random_text();
      int unsigned seq_n;
      int unsigned sel;
      int unsigned n;
      string       kw;
      string       singles;
      singles = "+*/(){};\n \t\r\f";
      seq_n = 0;
      while (source_q.size() < RANDOM_BYTES) begin
         // the first pass walks every kind but the near miss and the nul byte
         sel = (seq_n < 10) ? seq_n * 10 + 5 : $urandom_range(0, 99);
         if (sel < 15) begin
            // keyword, then something that ends it
            add_text(kw_word[$urandom_range(0, KW_COUNT - 1)]);
            add_byte(rand_break(), 1'b0);
         end else if (sel < 30) begin
            // identifier, now and then longer than the buffer
            if (seq_n == 1 || $urandom_range(0, 7) == 0)
               n = $urandom_range(MAX_NAME + 1, MAX_NAME + 8);
            else
               n = $urandom_range(1, 8);
            add_byte(rand_name_head(), 1'b0);
            for (int i = 1; i < n; i++)
               add_byte(rand_name_char(), 1'b0);
            add_byte(rand_break(), 1'b0);
         end else if (sel < 35) begin
            // near miss of a keyword: one character short or one too many
            kw = kw_word[$urandom_range(0, KW_COUNT - 1)];
            if ($urandom_range(0, 1))
               add_text(kw.substr(0, kw.len() - 2));
            else begin
               add_text(kw);
               add_byte(rand_name_char(), 1'b0);
            end
            add_byte(rand_break(), 1'b0);
         end else if (sel < 50) begin
            add_byte(singles[$urandom_range(0, singles.len() - 1)], 1'b0);
         end else if (sel < 60) begin
            // minus with blanks, then arrow head, newline or anything else
            add_byte("-", 1'b0);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
               add_byte(singles[$urandom_range(9, 12)], 1'b0);
            case ($urandom_range(0, 3))
               0, 1: add_byte(">", 1'b0);
               2:    add_byte(CH_NL, 1'b0);
               default: add_byte(rand_break(), 1'b0);
            endcase
         end else if (sel < 70) begin
            // compare, folded with '=' or closed by something else
            add_byte($urandom_range(0, 1) ? ">" : "<", 1'b0);
            add_byte($urandom_range(0, 1) ? "=" : rand_break(), 1'b0);
         end else if (sel < 85) begin
            add_byte(8'($urandom_range(1, 255)), 1'b0);
         end else if (sel < 90) begin
            // end word with a random byte that must be ignored
            add_byte(8'($urandom_range(0, 255)), 1'b1);
         end else if (sel < 92) begin
            add_byte(CH_NUL, 1'b0);
         end else begin
            add_byte(CH_NL, 1'b0);
         end
         seq_n++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // driver: presents one source word at a time; the payload only moves
   // after the word in flight was taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_proc
      src_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            lex_byte(req_text_byte, req_end_of_input);
         if (!req_valid || !req_stall) begin
            if (source_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
               w = source_q.pop_front();
               req_valid        <= 1'b1;
               req_text_byte    <= w.text;
               req_end_of_input <= w.eoi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: every taken token word is checked against the oldest
   // expectation; stall is thrown in at random
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_proc
      token_word_type got;
      token_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_char_out, rsp_char_index, rsp_last, rsp_truncated,
                    rsp_line};
            if (token_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display({"unexpected token word: kind %0d char %h idx %0d last %b",
                            " trunc %b line %0d"},
                           got.kind, got.ch, got.idx, got.last, got.trunc, got.line);
            end else begin
               want = token_expect_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display({"token word differs (expected/actual): kind %0d/%0d char %h/%h",
                               " idx %0d/%0d last %b/%b trunc %b/%b line %0d/%0d"},
                              want.kind, got.kind, want.ch, got.ch, want.idx, got.idx,
                              want.last, got.last, want.trunc, got.trunc, want.line, got.line);
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 14);
      end
   end

   // hard stop if the block hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("source_tokenizer_top: mismatch");
      $finish;
   end

   initial begin
      // directed opening: every single-character operator, a spaced arrow, both folded
      // compares, a keyword, a high byte, a minus flushed by an end word
      // carrying a byte, and a nul byte
      add_text("+*/(){};");
      add_text("- \t>");
      add_text(">=<=");
      add_text("pub ");
      add_byte(8'h80, 1'b0);
      add_byte(CH_NL, 1'b0);
      add_byte("-", 1'b0);
      add_byte("A", 1'b1);
      add_byte(CH_NUL, 1'b0);
      add_random_text();
      // a last end word flushes anything still pending
      add_byte(8'hFF, 1'b1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (source_q.size() != 0 || req_valid)
         @(posedge clock);
      while (token_expect_q.size() != 0)
         @(posedge clock);
      // let any stray word show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      fail_count += token_expect_q.size();
      if (fail_count == 0)
         $display("source_tokenizer_top: match");
      else
         $display("source_tokenizer_top: mismatch");
      $finish;
   end

endmodule
